// ===== sv/polygon_star_vertex_generator_macros.svh =====
// Assertion macros shared by the polygon and star vertex generator RTL.
`ifndef POLYGON_STAR_VERTEX_GENERATOR_MACROS_SVH
`define POLYGON_STAR_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define PSV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define PSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PSV_ASSERT_SAME(lbl, ante, cons)
`define PSV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/psv_pkg.sv =====
// Types and constants shared by the polygon and star vertex generator.
package psv_pkg;

  localparam int CORDIC_N = 30;
  localparam int XW = 34;

  localparam logic [24:0] DEG360 = 25'd23592960;
  localparam logic [24:0] DEG_BIAS = 25'd524288;
  // Reciprocals of 45: 2^19 / 45 and 2^30 / 45, rounded up.
  localparam logic [13:0] RCP45_HI = 14'd11651;
  localparam logic [24:0] RCP45_M = 25'd23860930;
  localparam logic signed [XW-1:0] GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN [CORDIC_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] outer_radius;
    logic signed [31:0] inner_radius;
    logic signed [31:0] rotation_deg;
    logic [4:0]         point_count;
    logic               star_mode;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               is_move;
    logic               is_last;
  } out_t;

  // Per-vertex data that rides along the trig pipeline.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] rad;
    logic               mv;
    logic               last;
  } pnt_t;

endpackage

// ===== sv/psv_seq.sv =====
// Request sequencer: angle reduction, arc step setup and vertex issue.
module psv_seq #(
  parameter int MAX_POINTS = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  psv_pkg::in_t  in_data,
  input  logic          adv,
  output logic          iss_valid,
  output logic [31:0]   iss_ang,
  output psv_pkg::pnt_t iss_pnt
);
  import psv_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MODR, S_BIAS, S_ANGL, S_STRT, S_RCPR, S_EMIT} state_t;

  state_t      state_r;
  in_t         req_r;
  logic [5:0]  dcnt_r;
  logic [37:0] dvd_r;
  logic [24:0] rem_r;
  logic [24:0] dvs_r;
  logic [5:0]  bit_r;
  logic [24:0] m_r;
  logic [18:0] q2_r;
  logic [31:0] start_r;
  logic [32:0] qinc_r;
  logic [5:0]  rinc_r;
  logic [32:0] qacc_r;
  logic [5:0]  racc_r;
  logic [5:0]  j_r;

  logic [25:0] trial;
  logic        ge;
  logic [24:0] rem_nxt;
  logic [37:0] dvd_nxt;
  logic [24:0] m_nxt;
  logic [4:0]  cnt_sat;
  logic [5:0]  dcnt_nxt;
  logic [6:0]  rsum;
  logic [31:0] rot_u;
  logic [26:0] hprod;
  logic [7:0]  hq;
  logic [12:0] hm45;
  logic [12:0] hr;
  logic [24:0] rem_mod;
  logic [49:0] mprod;
  logic [24:0] mq45;
  logic [24:0] bsub;
  logic [12:0] tab;

  // One restoring division step for the arc step reciprocal.
  always_comb begin
    trial   = {rem_r, dvd_r[37]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? 25'(trial - {1'b0, dvs_r}) : trial[24:0];
    dvd_nxt = {dvd_r[36:0], ge};
  end

  // Angle reduction: the full turn is 45 * 2^19, so only the top 13 bits need
  // a remainder by 45, done by reciprocal multiplication.
  always_comb begin
    rot_u   = req_r.rotation_deg ^ 32'h8000_0000;
    hprod   = {14'd0, rot_u[31:19]} * {13'd0, RCP45_HI};
    hq      = hprod[26:19];
    hm45    = {5'd0, hq} * 13'd45;
    hr      = rot_u[31:19] - hm45;
    rem_mod = {hr[5:0], rot_u[18:0]};
    m_nxt   = (rem_r >= DEG_BIAS) ? (rem_r - DEG_BIAS) : (rem_r + DEG360 - DEG_BIAS);
  end

  // Angle scaling: start = m * 2^13 / 45 = q * 2^13 + floor(2^13 * b / 45), with
  // m = 45 q + b; 2^13 = 45 * 182 + 2 gives the second term as 182 b, plus one from b = 23.
  always_comb begin
    mprod = {25'd0, m_r} * {25'd0, RCP45_M};
    mq45  = {6'd0, q2_r} * 25'd45;
    bsub  = m_r - mq45;
    tab   = {7'd0, bsub[5:0]} * 13'd182 + {12'd0, bsub[5:0] >= 6'd23};
  end

  // Step count: twice the point count in star mode.
  always_comb begin
    cnt_sat  = (in_data.point_count > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : in_data.point_count;
    dcnt_nxt = in_data.star_mode ? {cnt_sat, 1'b0} : {1'b0, cnt_sat};
    rsum     = {1'b0, racc_r} + {1'b0, rinc_r};
  end

  // Vertex issue toward the trig pipeline.
  always_comb begin
    in_stall      = state_r != S_IDLE;
    iss_valid     = (state_r == S_EMIT) && adv;
    iss_ang       = start_r + qacc_r[31:0];
    iss_pnt.cx    = req_r.center_x;
    iss_pnt.cy    = req_r.center_y;
    iss_pnt.rad   = (req_r.star_mode && j_r[0]) ? req_r.inner_radius : req_r.outer_radius;
    iss_pnt.mv    = j_r == 6'd0;
    iss_pnt.last  = j_r == dcnt_r;
  end

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            dcnt_r  <= dcnt_nxt;
            state_r <= S_MODR;
          end
        end
        S_MODR: begin
          rem_r   <= rem_mod;
          state_r <= S_BIAS;
        end
        S_BIAS: begin
          m_r     <= m_nxt;
          state_r <= S_ANGL;
        end
        S_ANGL: begin
          q2_r    <= mprod[48:30];
          state_r <= S_STRT;
        end
        S_STRT: begin
          start_r <= {q2_r, tab};
          qacc_r  <= '0;
          racc_r  <= '0;
          j_r     <= '0;
          qinc_r  <= '0;
          rinc_r  <= '0;
          if (dcnt_r == 6'd0) begin
            state_r <= S_EMIT;
          end else begin
            dvd_r   <= {1'b1, 37'd0};
            rem_r   <= '0;
            dvs_r   <= {19'd0, dcnt_r};
            bit_r   <= 6'd32;
            state_r <= S_RCPR;
          end
        end
        S_RCPR: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          bit_r <= bit_r - 6'd1;
          if (bit_r == 6'd0) begin
            qinc_r  <= dvd_nxt[32:0];
            rinc_r  <= rem_nxt[5:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (adv) begin
            if (j_r == dcnt_r) begin
              state_r <= S_IDLE;
            end else begin
              j_r <= j_r + 6'd1;
              if (rsum >= {1'b0, dcnt_r}) begin
                racc_r <= 6'(rsum - {1'b0, dcnt_r});
                qacc_r <= qacc_r + qinc_r + 33'd1;
              end else begin
                racc_r <= rsum[5:0];
                qacc_r <= qacc_r + qinc_r;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/psv_cordic.sv =====
// Pipelined rotation CORDIC, one register stage per iteration.
module psv_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [31:0]         in_ang,
  input  psv_pkg::pnt_t       in_pnt,
  output logic                out_valid,
  output logic signed [33:0]  out_cos,
  output logic signed [33:0]  out_sin,
  output psv_pkg::pnt_t       out_pnt
);
  import psv_pkg::*;

  logic                 v_r [CORDIC_N+1];
  logic signed [XW-1:0] x_r [CORDIC_N+1];
  logic signed [XW-1:0] y_r [CORDIC_N+1];
  logic signed [XW-1:0] z_r [CORDIC_N+1];
  logic                 f_r [CORDIC_N+1];
  pnt_t                 p_r [CORDIC_N+1];

  logic signed [XW-1:0] z0;
  logic signed [XW-1:0] z0_adj;
  logic                 flip0;

  // Fold angles beyond a quarter turn by a half turn.
  always_comb begin
    z0 = {{(XW-32){in_ang[31]}}, in_ang};
    if (z0 > 34'sh0_4000_0000) begin
      z0_adj = z0 - 34'sh0_8000_0000;
      flip0  = 1'b1;
    end else if (z0 < -34'sh0_4000_0000) begin
      z0_adj = z0 + 34'sh0_8000_0000;
      flip0  = 1'b1;
    end else begin
      z0_adj = z0;
      flip0  = 1'b0;
    end
  end

  // Entry stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= GAIN;
      y_r[0] <= '0;
      z_r[0] <= z0_adj;
      f_r[0] <= flip0;
      p_r[0] <= in_pnt;
    end
  end

  // Micro-rotation stages.
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] at;

    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign at = {{(XW-32){1'b0}}, ATAN[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + at;
        end
        f_r[i+1] <= f_r[i];
        p_r[i+1] <= p_r[i];
      end
    end
  end

  // Undo the half-turn fold.
  always_comb begin
    out_valid = v_r[CORDIC_N];
    out_cos   = f_r[CORDIC_N] ? -x_r[CORDIC_N] : x_r[CORDIC_N];
    out_sin   = f_r[CORDIC_N] ? -y_r[CORDIC_N] : y_r[CORDIC_N];
    out_pnt   = p_r[CORDIC_N];
  end

endmodule

// ===== sv/psv_vtx.sv =====
// Vertex stage: radius scaling, rounding, center offset and saturation.
module psv_vtx (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [33:0] in_cos,
  input  logic signed [33:0] in_sin,
  input  psv_pkg::pnt_t      in_pnt,
  output logic               out_valid,
  output psv_pkg::out_t      out_data
);
  import psv_pkg::*;

  logic               va_r;
  logic signed [65:0] pxa_r;
  logic signed [65:0] pya_r;
  pnt_t               pa_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [65:0] px;
  logic signed [65:0] py;
  logic signed [65:0] rx;
  logic signed [65:0] ry;
  logic signed [36:0] sx;
  logic signed [36:0] sy;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -37'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Radius times trig value.
  always_comb begin
    px = in_pnt.rad * in_cos;
    py = in_pnt.rad * in_sin;
  end

  // Round to nearest, add center.
  always_comb begin
    rx = pxa_r + 66'sd536870912;
    ry = pya_r + 66'sd536870912;
    sx = {{5{pa_r.cx[31]}}, pa_r.cx} + {rx[65], rx[65:30]};
    sy = {{5{pa_r.cy[31]}}, pa_r.cy} + {ry[65], ry[65:30]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= in_valid;
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxa_r               <= px;
      pya_r               <= py;
      pa_r                <= in_pnt;
      out_data_r.vertex_x <= sat32(sx);
      out_data_r.vertex_y <= sat32(sy);
      out_data_r.is_move  <= pa_r.mv;
      out_data_r.is_last  <= pa_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/polygon_star_vertex_generator.sv =====
// Polygon and star outline vertex generator, Q16.16 fixed point.
// Per request: angle reduction and scaling, then arc step setup by restoring division (skipped for
// a zero count), then one vertex issued per cycle unless the output stalls; the next request is
// taken once the sequencer has returned to idle after the last vertex.
// Synchronous active-low reset clears the sequencer state and all stage valid bits.
`include "polygon_star_vertex_generator_macros.svh"
module polygon_star_vertex_generator #(
  parameter int MAX_POINTS = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  psv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output psv_pkg::out_t out_data
);
  import psv_pkg::*;

  logic               adv;
  logic               iss_valid;
  logic [31:0]        iss_ang;
  pnt_t               iss_pnt;
  logic               cor_valid;
  logic signed [33:0] cor_cos;
  logic signed [33:0] cor_sin;
  pnt_t               cor_pnt;

  // The whole pipeline moves unless a held output word is stalled.
  assign adv = !(out_valid && out_stall);

  psv_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .adv       (adv),
    .iss_valid (iss_valid),
    .iss_ang   (iss_ang),
    .iss_pnt   (iss_pnt)
  );

  psv_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (iss_valid),
    .in_ang    (iss_ang),
    .in_pnt    (iss_pnt),
    .out_valid (cor_valid),
    .out_cos   (cor_cos),
    .out_sin   (cor_sin),
    .out_pnt   (cor_pnt)
  );

  psv_vtx u_vtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cor_valid),
    .in_cos    (cor_cos),
    .in_sin    (cor_sin),
    .in_pnt    (cor_pnt),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A new request keeps the input side busy.
  `PSV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A frozen pipeline keeps its words.
  `PSV_ASSERT_NEXT(a_pipe_frozen, !adv && cor_valid, cor_valid)
  // Vertices are only issued while the pipeline moves.
  `PSV_ASSERT_SAME(a_issue_moves, iss_valid, adv)

endmodule
